// ===== src/quotient_filter_lookup_unit_macros.svh =====
// assertion macros for the quotient filter lookup unit checker
// expects clk and rst in the scope of each use
`ifndef QUOTIENT_FILTER_LOOKUP_UNIT_MACROS_SVH
`define QUOTIENT_FILTER_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define QFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qfl assertion failed");

// next-cycle implication, disabled in reset
`define QFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qfl assertion failed");

// what must hold in the cycle after reset is seen
`define QFL_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("qfl reset assertion failed");

`endif

// ===== src/qfl_pkg.sv =====
// shared constants, codes and state type of the quotient filter lookup unit
// no dependencies
`default_nettype none

package qfl_pkg;

  localparam int MAX_QUOTIENT_BITS  = 10;
  localparam int MAX_REMAINDER_BITS = 16;

  localparam int DEPTH   = 1 << MAX_QUOTIENT_BITS;
  localparam int SLOT_W  = MAX_QUOTIENT_BITS;
  localparam int STEP_W  = MAX_QUOTIENT_BITS + 1;
  localparam int REM_W   = MAX_REMAINDER_BITS;
  localparam int FP_W    = 26;
  localparam int QBITS_W = 4;
  localparam int RBITS_W = 5;
  localparam int FLAG_W  = 3;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_QUOTIENT_BITS  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_REMAINDER_BITS = CFG_INDEX_W'(1);

  localparam logic [QBITS_W-1:0] QBITS_RESET = QBITS_W'(10);
  localparam logic [RBITS_W-1:0] RBITS_RESET = RBITS_W'(8);

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // flag bit positions in a slot
  localparam int FLAG_OCC   = 0;
  localparam int FLAG_CONT  = 1;
  localparam int FLAG_SHIFT = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_CANON,
    ST_BACK,
    ST_SKIP,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/qfl_ifs.sv =====
// channel interfaces of the quotient filter lookup unit: request, response, config
// depends on qfl_pkg
`default_nettype none

interface qfl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [qfl_pkg::SLOT_W-1:0]  slot_index;
  logic [qfl_pkg::REM_W-1:0]   slot_remainder;
  logic                        slot_occupied;
  logic                        slot_continuation;
  logic                        slot_shifted;
  logic [qfl_pkg::FP_W-1:0]    fingerprint;

  modport source (output valid, func, slot_index, slot_remainder, slot_occupied,
                  slot_continuation, slot_shifted, fingerprint, input ready);
  modport sink   (input valid, func, slot_index, slot_remainder, slot_occupied,
                  slot_continuation, slot_shifted, fingerprint, output ready);
endinterface

interface qfl_rsp_if;
  logic valid;
  logic ready;
  logic was_query;
  logic found;

  modport source (output valid, was_query, found, input ready);
  modport sink   (input valid, was_query, found, output ready);
endinterface

interface qfl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qfl_pkg::CFG_INDEX_W-1:0] index;
  logic [qfl_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/quotient_filter_lookup_unit.sv =====
// quotient filter lookup unit: slot table in two memories, query sequencer
// depends on qfl_pkg and the channel interfaces in qfl_ifs.sv
//
//   channel | dir | carries                                   | transfer when
//   req     | in  | func, slot fields, fingerprint            | req.valid && req.ready
//   rsp     | out | was_query, found                          | rsp.valid && rsp.ready
//   cfg     | in  | index, wdata (quotient_bits, remainder_bits) | cfg.valid && cfg.ready
//
// a write goes from transfer through ST_DONE to a loaded response register
// a query reads the canonical slot, then walks back to the cluster start, skips runs forward,
// and scans the run, with one flags/remainder memory read per cycle
// after reset a clearing pass over every slot zeroes the flags memory; req is held off
// cfg is always ready; a query keeps working while a previous response stalls
`default_nettype none

module quotient_filter_lookup_unit (
  input  wire logic clk,
  input  wire logic rst,
  qfl_req_if.sink   req,
  qfl_rsp_if.source rsp,
  qfl_cfg_if.sink   cfg
);

  qfl_pkg::state_t state, state_next;

  logic [qfl_pkg::QBITS_W-1:0] qbits;
  logic [qfl_pkg::RBITS_W-1:0] rbits;
  logic [qfl_pkg::QBITS_W-1:0] q_eff;
  logic [qfl_pkg::RBITS_W-1:0] r_eff;
  logic [qfl_pkg::STEP_W-1:0]  nslots;
  logic [qfl_pkg::SLOT_W-1:0]  qmask;
  logic [qfl_pkg::REM_W:0]     rmask_wide;
  logic [qfl_pkg::REM_W-1:0]   rmask;

  logic [qfl_pkg::FLAG_W-1:0] flag_mem [qfl_pkg::DEPTH];
  logic [qfl_pkg::REM_W-1:0]  rem_mem  [qfl_pkg::DEPTH];
  logic [qfl_pkg::FLAG_W-1:0] flags_q;
  logic [qfl_pkg::REM_W-1:0]  rem_q;

  logic [qfl_pkg::SLOT_W-1:0] clr_cnt;
  logic [qfl_pkg::FP_W-1:0]   fp;
  logic [qfl_pkg::REM_W-1:0]  want, want_next;
  logic [qfl_pkg::SLOT_W-1:0] pos, pos_next;
  logic [qfl_pkg::STEP_W-1:0] steps, steps_next;
  logic [qfl_pkg::STEP_W-1:0] count, count_next;
  logic                       chk, chk_next;
  logic                       res_isq, res_isq_next;
  logic                       res_found, res_found_next;

  logic                       req_xfer, cfg_xfer, rsp_free;
  logic                       occ, cont, shift;
  logic [qfl_pkg::STEP_W-1:0] count_sum;
  logic                       step_last;
  logic [qfl_pkg::FP_W-1:0]   fp_shr;
  logic [qfl_pkg::SLOT_W-1:0] canon;
  logic [qfl_pkg::REM_W-1:0]  have;
  logic [qfl_pkg::SLOT_W-1:0] pos_inc, pos_dec;

  logic                       flag_we;
  logic [qfl_pkg::SLOT_W-1:0] flag_waddr;
  logic [qfl_pkg::FLAG_W-1:0] flag_wdata;
  logic                       rem_we;

  assign req.ready = (state == qfl_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_xfer  = req.valid && req.ready;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign rsp_free  = !rsp.valid || rsp.ready;

  // saturated register values
  always_comb begin
    q_eff = qbits;
    if (qbits == '0) q_eff = qfl_pkg::QBITS_W'(1);
    else if (qbits > qfl_pkg::QBITS_W'(qfl_pkg::MAX_QUOTIENT_BITS))
      q_eff = qfl_pkg::QBITS_W'(qfl_pkg::MAX_QUOTIENT_BITS);
    r_eff = rbits;
    if (rbits == '0) r_eff = qfl_pkg::RBITS_W'(1);
    else if (rbits > qfl_pkg::RBITS_W'(qfl_pkg::MAX_REMAINDER_BITS))
      r_eff = qfl_pkg::RBITS_W'(qfl_pkg::MAX_REMAINDER_BITS);
  end

  assign nslots     = qfl_pkg::STEP_W'(1) << q_eff;
  assign qmask      = qfl_pkg::SLOT_W'(nslots - qfl_pkg::STEP_W'(1));
  assign rmask_wide = ((qfl_pkg::REM_W+1)'(1) << r_eff) - (qfl_pkg::REM_W+1)'(1);
  assign rmask      = rmask_wide[qfl_pkg::REM_W-1:0];

  assign occ       = flags_q[qfl_pkg::FLAG_OCC];
  assign cont      = flags_q[qfl_pkg::FLAG_CONT];
  assign shift     = flags_q[qfl_pkg::FLAG_SHIFT];
  assign count_sum = count + qfl_pkg::STEP_W'(occ);
  assign step_last = (steps == {1'b0, qmask});
  assign fp_shr    = fp >> r_eff;
  assign canon     = fp_shr[qfl_pkg::SLOT_W-1:0] & qmask;
  assign have      = rem_q & rmask;
  assign pos_inc   = (pos + qfl_pkg::SLOT_W'(1)) & qmask;
  assign pos_dec   = (pos - qfl_pkg::SLOT_W'(1)) & qmask;

  // memory write port: clearing pass or slot load
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = req.slot_index;
    flag_wdata = {req.slot_shifted, req.slot_continuation, req.slot_occupied};
    rem_we     = 1'b0;
    if (state == qfl_pkg::ST_CLEAR) begin
      flag_we    = 1'b1;
      flag_waddr = clr_cnt;
      flag_wdata = '0;
    end else if (req_xfer && req.func == qfl_pkg::FUNC_WRITE) begin
      flag_we = 1'b1;
      rem_we  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    if (rem_we) rem_mem[req.slot_index] <= req.slot_remainder;
    flags_q <= flag_mem[pos_next];
    rem_q   <= rem_mem[pos_next];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      qfl_pkg::ST_CLEAR: begin
        if (clr_cnt == qfl_pkg::SLOT_W'(qfl_pkg::DEPTH - 1)) state_next = qfl_pkg::ST_IDLE;
      end
      qfl_pkg::ST_IDLE: begin
        if (req_xfer) begin
          if (req.func == qfl_pkg::FUNC_WRITE) state_next = qfl_pkg::ST_DONE;
          else state_next = qfl_pkg::ST_START;
        end
      end
      qfl_pkg::ST_START: state_next = qfl_pkg::ST_CANON;
      qfl_pkg::ST_CANON: begin
        if (!occ) state_next = qfl_pkg::ST_DONE;
        else if (shift) state_next = qfl_pkg::ST_BACK;
        else state_next = qfl_pkg::ST_SCAN;
      end
      qfl_pkg::ST_BACK: begin
        if (!shift) begin
          if (count_sum == '0) state_next = qfl_pkg::ST_SCAN;
          else state_next = qfl_pkg::ST_SKIP;
        end else if (step_last) begin
          state_next = qfl_pkg::ST_DONE;
        end
      end
      qfl_pkg::ST_SKIP: begin
        if (!cont) begin
          if (count == qfl_pkg::STEP_W'(1)) state_next = qfl_pkg::ST_SCAN;
        end else if (step_last) begin
          state_next = qfl_pkg::ST_DONE;
        end
      end
      qfl_pkg::ST_SCAN: begin
        if ((chk && !cont) || steps == nslots || have >= want) state_next = qfl_pkg::ST_DONE;
      end
      qfl_pkg::ST_DONE: begin
        if (rsp_free) state_next = qfl_pkg::ST_IDLE;
      end
      default: state_next = qfl_pkg::ST_CLEAR;
    endcase
  end

  // datapath next values
  always_comb begin
    pos_next       = pos;
    steps_next     = steps;
    count_next     = count;
    chk_next       = chk;
    want_next      = want;
    res_isq_next   = res_isq;
    res_found_next = res_found;
    case (state)
      qfl_pkg::ST_IDLE: begin
        if (req_xfer) begin
          res_isq_next   = req.func;
          res_found_next = 1'b0;
        end
      end
      qfl_pkg::ST_START: begin
        pos_next  = canon;
        want_next = fp[qfl_pkg::REM_W-1:0] & rmask;
      end
      qfl_pkg::ST_CANON: begin
        steps_next = '0;
        count_next = '0;
        chk_next   = 1'b0;
        if (shift) pos_next = pos_dec;
      end
      qfl_pkg::ST_BACK: begin
        count_next = count_sum;
        if (!shift) begin
          steps_next = '0;
          if (count_sum != '0) pos_next = pos_inc;
        end else begin
          steps_next = steps + qfl_pkg::STEP_W'(1);
          pos_next   = pos_dec;
        end
      end
      qfl_pkg::ST_SKIP: begin
        if (!cont) begin
          count_next = count - qfl_pkg::STEP_W'(1);
          steps_next = '0;
          if (count != qfl_pkg::STEP_W'(1)) pos_next = pos_inc;
        end else begin
          steps_next = steps + qfl_pkg::STEP_W'(1);
          pos_next   = pos_inc;
        end
      end
      qfl_pkg::ST_SCAN: begin
        if ((chk && !cont) || steps == nslots) begin
          res_found_next = 1'b0;
        end else if (have == want) begin
          res_found_next = 1'b1;
        end else if (have < want) begin
          steps_next = steps + qfl_pkg::STEP_W'(1);
          pos_next   = pos_inc;
          chk_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qfl_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      qbits     <= qfl_pkg::QBITS_RESET;
      rbits     <= qfl_pkg::RBITS_RESET;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == qfl_pkg::ST_CLEAR) clr_cnt <= clr_cnt + qfl_pkg::SLOT_W'(1);
      if (cfg_xfer) begin
        case (cfg.index)
          qfl_pkg::REG_QUOTIENT_BITS:  qbits <= cfg.wdata[qfl_pkg::QBITS_W-1:0];
          qfl_pkg::REG_REMAINDER_BITS: rbits <= cfg.wdata[qfl_pkg::RBITS_W-1:0];
          default: begin
          end
        endcase
      end
      if (state == qfl_pkg::ST_DONE && rsp_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_xfer) fp <= req.fingerprint;
    pos       <= pos_next;
    steps     <= steps_next;
    count     <= count_next;
    chk       <= chk_next;
    want      <= want_next;
    res_isq   <= res_isq_next;
    res_found <= res_found_next;
    if (state == qfl_pkg::ST_DONE && rsp_free) begin
      rsp.was_query <= res_isq;
      rsp.found     <= res_found;
    end
  end

endmodule

`default_nettype wire

// ===== src/qfl_checker.sv =====
// port-level checks of the quotient filter lookup unit, bound to the top level
// depends on quotient_filter_lookup_unit_macros.svh and the top level's ports
`default_nettype none

`include "quotient_filter_lookup_unit_macros.svh"

module qfl_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic rsp_was_query,
  input wire logic rsp_found
);

  `QFL_ASSERT_RST(a_reset_quiet, !req_ready && !rsp_valid)
  `QFL_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `QFL_ASSERT_IMP(a_write_ack_not_found, rsp_valid && !rsp_was_query, !rsp_found)
  `QFL_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind quotient_filter_lookup_unit qfl_checker u_qfl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_was_query (rsp.was_query),
  .rsp_found     (rsp.found)
);

`default_nettype wire
